### sv/double_ended_queue_assert.svh
// Assertion macros shared by the deque modules.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check an invariant at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/deq_pkg.sv
// Shared constants, codes and control types of the double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_POP_REAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic read;
        logic load;
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
    } deq_stat_t;

endpackage

### sv/deq_if.sv
// Valid/ready channel interfaces for requests and responses.
interface deq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::FUNC_W-1:0]           func;
    logic signed [deq_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::STATUS_W-1:0]         status;
    logic [deq_pkg::COUNT_W-1:0]          count;
    logic signed [deq_pkg::VALUE_W-1:0]   front_value;
    logic signed [deq_pkg::VALUE_W-1:0]   rear_value;

    modport source (output valid, output status, output count, output front_value,
                    output rear_value, input ready);
    modport sink   (input valid, input status, input count, input front_value,
                    input rear_value, output ready);
endinterface

### sv/deq_ctrl.sv
// Sequencer of the deque: accept, execute, read, load the response.
module deq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the response register is free
                cmd.load = stat.slot_free;
                if (stat.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`include "double_ended_queue_assert.svh"

    `DEQ_ASSERT_NEXT(a_accept_starts_exec, req_valid && req_ready, state_reg == S_EXEC, "accept did not start execution")

endmodule

### sv/deq_dp.sv
// Datapath of the deque: ring pointers, entry store and response register.
module deq_dp
#(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  deq_pkg::deq_cmd_t                   cmd,
    output deq_pkg::deq_stat_t                  stat,
    input  logic [deq_pkg::FUNC_W-1:0]          req_func,
    input  logic signed [deq_pkg::VALUE_W-1:0]  req_value,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [deq_pkg::STATUS_W-1:0]        rsp_status,
    output logic [deq_pkg::COUNT_W-1:0]         rsp_count,
    output logic signed [deq_pkg::VALUE_W-1:0]  rsp_front_value,
    output logic signed [deq_pkg::VALUE_W-1:0]  rsp_rear_value
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);
    localparam int SUMW = IDXW + 3;

    logic [deq_pkg::FUNC_W-1:0]   func_reg;
    logic [deq_pkg::VALUE_W-1:0]  value_reg;
    logic [IDXW-1:0]              head_reg;
    logic [IDXW-1:0]              head_next;
    logic [IDXW-1:0]              tail_reg;
    logic [IDXW-1:0]              tail_next;
    logic [CNTW-1:0]              cnt_reg;
    logic [CNTW-1:0]              cnt_next;
    logic [deq_pkg::STATUS_W-1:0] status_reg;
    logic [deq_pkg::STATUS_W-1:0] status_next;

    logic [deq_pkg::VALUE_W-1:0]  mem [DEPTH];
    logic [deq_pkg::VALUE_W-1:0]  rd_front_reg;
    logic [deq_pkg::VALUE_W-1:0]  rd_rear_reg;

    logic                         out_valid_reg;
    logic [deq_pkg::STATUS_W-1:0] out_status_reg;
    logic [deq_pkg::COUNT_W-1:0]  out_count_reg;
    logic [deq_pkg::VALUE_W-1:0]  out_front_reg;
    logic [deq_pkg::VALUE_W-1:0]  out_rear_reg;

    logic            full;
    logic            empty;
    logic [IDXW-1:0] head_inc;
    logic [IDXW-1:0] head_dec;
    logic [IDXW-1:0] tail_inc;
    logic [IDXW-1:0] tail_dec;
    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    logic [SUMW-1:0] tail_sum;
    logic [IDXW-1:0] tail_expect;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    // Execute the latched operation: move one end, count, status, store write.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        status_next = deq_pkg::ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = head_dec;
        unique case (func_reg)
            deq_pkg::FN_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    head_next = head_dec;
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            deq_pkg::FN_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    tail_next = tail_inc;
                    wr_en     = 1'b1;
                    wr_addr   = tail_inc;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            deq_pkg::FN_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            deq_pkg::FN_POP_REAR:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    tail_next = tail_dec;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = deq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= LAST_IDX;
            cnt_reg    <= '0;
            status_reg <= deq_pkg::ST_DONE;
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= req_func;
            value_reg <= req_value;
        end
    end

    // Entry store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.read)
        begin
            rd_front_reg <= mem[head_reg];
            rd_rear_reg  <= mem[tail_reg];
        end
    end

    assign stat.slot_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= deq_pkg::COUNT_W'(cnt_reg);
            out_front_reg  <= empty ? '0 : rd_front_reg;
            out_rear_reg   <= empty ? '0 : rd_rear_reg;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_count       = out_count_reg;
    assign rsp_front_value = out_front_reg;
    assign rsp_rear_value  = out_rear_reg;

    // Expected rear index from head and count, reduced below DEPTH.
    assign tail_sum = SUMW'(head_reg) + SUMW'(cnt_reg) + SUMW'(DEPTH - 1);
    always_comb
    begin
        priority if (tail_sum < SUMW'(DEPTH))
        begin
            tail_expect = IDXW'(tail_sum);
        end
        else if (tail_sum < SUMW'(2 * DEPTH))
        begin
            tail_expect = IDXW'(tail_sum - SUMW'(DEPTH));
        end
        else
        begin
            tail_expect = IDXW'(tail_sum - SUMW'(2 * DEPTH));
        end
    end

`include "double_ended_queue_assert.svh"

    `DEQ_ASSERT_ALWAYS(a_cnt_bounded, cnt_reg <= FULL_CNT, "entry count above depth")
    `DEQ_ASSERT_ALWAYS(a_ring_relation, tail_reg == tail_expect, "rear index out of step with head and count")
    `DEQ_ASSERT_NEXT(a_empty_pop_underflow, cmd.exec && empty && (func_reg == deq_pkg::FN_POP_FRONT || func_reg == deq_pkg::FN_POP_REAR), status_reg == deq_pkg::ST_UNDERFLOW && cnt_reg == '0, "pop from empty queue not reported")
    `DEQ_ASSERT_SAME(a_load_slot_free, cmd.load, !out_valid_reg || rsp_ready, "response overwritten before it was taken")

endmodule

### sv/double_ended_queue.sv
// An accepted request goes through execute, read and load before its response is valid;
// load waits while the previous response is still pending. No new request is taken
// until that load is done. The entry store has a single write and a dual read port.
// A new request is taken while the previous response still waits to be taken.
// Reset clears head to 0, tail to DEPTH-1, count to 0 and drops any pending response;
// the entry store is not cleared, there is no clearing pass.
module double_ended_queue
#(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_stat_t stat;

    // Drive each transaction through the datapath one step per cycle; load may stall.
    deq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the ring pointers, the entry store and the response register.
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_func        (req.func),
        .req_value       (req.value),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_status      (rsp.status),
        .rsp_count       (rsp.count),
        .rsp_front_value (rsp.front_value),
        .rsp_rear_value  (rsp.rear_value)
    );

endmodule
